/* design/arc_pkg.sv */
// arc_pkg: shared types, codes and sizes for the arp resolution cache
// used by arc_ctrl, arc_dp and arp_resolver_cache_unit; no dependencies
`default_nettype none
package arc_pkg;
    localparam int CacheEntries = 16;
    localparam int PendEntries  = 16;
    localparam int ReqEntries   = 16;
    localparam int CIdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
    localparam int PIdxW = (PendEntries > 1) ? $clog2(PendEntries) : 1;
    localparam int RIdxW = (ReqEntries > 1) ? $clog2(ReqEntries) : 1;
    localparam int PCntW = $clog2(PendEntries + 1);

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RECV = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] KIND_IPV4    = 2'd0;
    localparam logic [1:0] KIND_ARP_REQ = 2'd1;
    localparam logic [1:0] KIND_ARP_REP = 2'd2;
    localparam logic [1:0] KIND_DELIVER = 2'd3;

    localparam logic [1:0] REG_OWN_MAC = 2'd0;
    localparam logic [1:0] REG_OWN_IP  = 2'd1;
    localparam logic [1:0] REG_RETRY   = 2'd2;
    localparam logic [1:0] REG_LIFE    = 2'd3;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DECIDE= 7'b0000100,
        S_FLUSH = 7'b0001000,
        S_EMIT  = 7'b0010000,
        S_TICK  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic clr_scan;  // restart scan counter
        logic scan;      // one scan step over all tables
        logic decide;    // apply table updates after scan
        logic flush;     // one pending entry step
        logic tick;      // one aging step
        logic emit;      // push a result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic scan_done;
        logic flush_done;
        logic tick_done;
        logic has_result;   // a result is waiting to be emitted
        logic out_busy;     // output register full
    } t_sts;
endpackage
`default_nettype wire

/* design/arp_resolver_cache_unit.sv */
// arp_resolver_cache_unit: top level of the arp resolution cache
// depends on arc_pkg, arc_ctrl and arc_dp
//
// one event at a time: send, receive or tick; the next is taken once the
// previous one is done and its last result, if any, sits in the output
// register, which may still be stalled. every event walks the sixteen-entry
// tables one entry a cycle: an accept, the scan and an update, then the
// results; a tick walks them in 16 aging steps instead. an arp frame also
// steps through the parked datagrams, flushing each match, then gives a
// reply if one is due. results leave through a single output register,
// o_last on the final one; a stalled output holds the sequencer.
// registers sit on a 64-bit apb port at 8*i since own_mac is 48 bits
`default_nettype none
module arp_resolver_cache_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_dgram_tag,
    input  wire logic [31:0] i_next_hop_ip,
    input  wire logic [47:0] i_frame_dst_mac,
    input  wire logic        i_frame_is_ipv4,
    input  wire logic        i_parse_ok,
    input  wire logic        i_arp_is_request,
    input  wire logic [31:0] i_arp_sender_ip,
    input  wire logic [47:0] i_arp_sender_mac,
    input  wire logic [31:0] i_arp_target_ip,
    input  wire logic [15:0] i_elapsed_ms,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [47:0]      o_dst_mac,
    output logic [31:0]      o_target_ip,
    output logic [47:0]      o_target_mac,
    output logic [15:0]      o_out_tag,
    output logic             o_last
);
    // registers at 8*i on a 64-bit bus since own_mac is 48 bits
    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;
    logic [15:0] r_retry;
    logic [19:0] r_life;
    logic [1:0]  reg_idx;
    logic        wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= '0;
            r_retry   <= 16'd5000;
            r_life    <= 20'd30000;
        end else if (wr) begin
            unique case (reg_idx)
                arc_pkg::REG_OWN_MAC: r_own_mac <= pwdata[47:0];
                arc_pkg::REG_OWN_IP:  r_own_ip  <= pwdata[31:0];
                arc_pkg::REG_RETRY:   r_retry   <= pwdata[15:0];
                arc_pkg::REG_LIFE:    r_life    <= pwdata[19:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            arc_pkg::REG_OWN_MAC: prdata = {16'd0, r_own_mac};
            arc_pkg::REG_OWN_IP:  prdata = {32'd0, r_own_ip};
            arc_pkg::REG_RETRY:   prdata = {48'd0, r_retry};
            arc_pkg::REG_LIFE:    prdata = {44'd0, r_life};
        endcase
    end

    arc_pkg::t_cmd cmd;
    arc_pkg::t_sts sts;

    arc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op,
        .i_sts(sts), .o_cmd(cmd)
    );

    arc_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_op, .i_dgram_tag, .i_next_hop_ip, .i_frame_dst_mac, .i_frame_is_ipv4,
        .i_parse_ok, .i_arp_is_request, .i_arp_sender_ip, .i_arp_sender_mac,
        .i_arp_target_ip, .i_elapsed_ms,
        .i_own_mac(r_own_mac), .i_own_ip(r_own_ip), .i_retry_ms(r_retry),
        .i_life_ms(r_life),
        .o_valid, .i_ready, .o_kind, .o_dst_mac, .o_target_ip, .o_target_mac,
        .o_out_tag, .o_last
    );
endmodule
`default_nettype wire

/* design/arc_dp.sv */
// arc_dp: tables, scan counters and output register of the arp cache
// depends on arc_pkg
`default_nettype none
module arc_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire arc_pkg::t_cmd    i_cmd,
    output arc_pkg::t_sts         o_sts,
    input  wire logic [1:0]       i_op,
    input  wire logic [15:0]      i_dgram_tag,
    input  wire logic [31:0]      i_next_hop_ip,
    input  wire logic [47:0]      i_frame_dst_mac,
    input  wire logic             i_frame_is_ipv4,
    input  wire logic             i_parse_ok,
    input  wire logic             i_arp_is_request,
    input  wire logic [31:0]      i_arp_sender_ip,
    input  wire logic [47:0]      i_arp_sender_mac,
    input  wire logic [31:0]      i_arp_target_ip,
    input  wire logic [15:0]      i_elapsed_ms,
    input  wire logic [47:0]      i_own_mac,
    input  wire logic [31:0]      i_own_ip,
    input  wire logic [15:0]      i_retry_ms,
    input  wire logic [19:0]      i_life_ms,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [1:0]            o_kind,
    output logic [47:0]           o_dst_mac,
    output logic [31:0]           o_target_ip,
    output logic [47:0]           o_target_mac,
    output logic [15:0]           o_out_tag,
    output logic                  o_last
);
    localparam int CE = arc_pkg::CacheEntries;
    localparam int PE = arc_pkg::PendEntries;
    localparam int RE = arc_pkg::ReqEntries;
    localparam int MaxE = (CE > PE) ? ((CE > RE) ? CE : RE) : ((PE > RE) ? PE : RE);
    localparam int SW = $clog2(MaxE + 1);

    // tables (entries read at the scan pointer)
    logic [31:0] r_c_ip  [CE];
    logic [47:0] r_c_mac [CE];
    logic [19:0] r_c_age [CE];
    logic [CE-1:0] r_c_vld;
    logic [31:0] r_p_ip  [PE];
    logic [15:0] r_p_tag [PE];
    logic [PE-1:0] r_p_vld;
    logic [31:0] r_q_ip  [RE];
    logic [15:0] r_q_age [RE];
    logic [RE-1:0] r_q_vld;

    // captured item
    logic [1:0]  r_op;
    logic [15:0] r_tag;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic        r_rep;
    logic [15:0] r_el;
    logic        r_accept_frame;
    logic        r_is_ipv4;

    // scan results
    logic [SW-1:0] r_i;
    logic r_c_hit;  logic [arc_pkg::CIdxW-1:0] r_c_hidx;
    logic r_c_free; logic [arc_pkg::CIdxW-1:0] r_c_fidx;
    logic [arc_pkg::CIdxW-1:0] r_c_oidx; logic [19:0] r_c_omax;
    logic r_q_hit;  logic [arc_pkg::RIdxW-1:0] r_q_hidx;
    logic r_q_free; logic [arc_pkg::RIdxW-1:0] r_q_fidx;
    logic [arc_pkg::RIdxW-1:0] r_q_oidx; logic [15:0] r_q_omax;
    logic [arc_pkg::PCntW-1:0] r_p_cnt;
    // parked datagrams waiting for the sender ip, still to be flushed
    logic [arc_pkg::PCntW-1:0] r_m_cnt;

    // flush: read index r_i, write index r_w
    logic [arc_pkg::PCntW-1:0] r_w;
    logic        r_fdone;
    // pending result to emit
    logic        r_res;
    logic [1:0]  r_res_kind;
    logic [47:0] r_res_dmac;
    logic [31:0] r_res_tip;
    logic [47:0] r_res_tmac;
    logic [15:0] r_res_tag;
    logic        r_res_last;
    logic        r_reply_due;

    logic scan_done;
    assign scan_done = (r_i == SW'(MaxE));

    // pending flush helpers
    logic [arc_pkg::PIdxW-1:0] fi;
    logic fvalid;
    logic [SW-1:0] fnext;
    assign fi = r_i[arc_pkg::PIdxW-1:0];
    assign fvalid = (r_i < SW'(PE)) && r_p_vld[fi];
    assign fnext = r_i + SW'(1);

    // an accepted arp frame learns, flushes and may reply
    logic arp_learn;
    assign arp_learn = (r_op == arc_pkg::OP_RECV) && r_accept_frame && !r_is_ipv4;

    logic [20:0] c_sum;
    logic [16:0] q_sum;
    logic [arc_pkg::CIdxW-1:0] ci;
    logic [arc_pkg::RIdxW-1:0] qi;
    assign ci = r_i[arc_pkg::CIdxW-1:0];
    assign qi = r_i[arc_pkg::RIdxW-1:0];
    assign c_sum = {1'b0, r_c_age[ci]} + 21'(r_el);
    assign q_sum = {1'b0, r_q_age[qi]} + 17'(r_el);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= '0;
            r_p_vld <= '0;
            r_q_vld <= '0;
            r_res   <= 1'b0;
            r_fdone <= 1'b1;
            o_valid <= 1'b0;
            r_i     <= '0;
            for (int k = 0; k < CE; k++) begin
                r_c_age[k] <= '0;
                r_c_ip[k]  <= '0;
                r_c_mac[k] <= '0;
            end
            for (int k = 0; k < RE; k++) r_q_age[k] <= '0;
        end else begin
            if (i_cmd.load) begin
                r_op  <= i_op;
                r_tag <= i_dgram_tag;
                r_ip  <= (i_op == arc_pkg::OP_SEND) ? i_next_hop_ip : i_arp_sender_ip;
                r_mac <= i_arp_sender_mac;
                r_rep <= i_arp_is_request && (i_arp_target_ip == i_own_ip);
                r_el  <= i_elapsed_ms;
                r_is_ipv4 <= i_frame_is_ipv4;
                r_accept_frame <= ((i_frame_dst_mac == 48'hFFFF_FFFF_FFFF) ||
                                   (i_frame_dst_mac == i_own_mac)) && i_parse_ok;
            end
            if (i_cmd.clr_scan) begin
                r_i <= '0;
                r_c_hit <= 1'b0; r_c_free <= 1'b0; r_c_oidx <= '0; r_c_omax <= r_c_age[0];
                r_q_hit <= 1'b0; r_q_free <= 1'b0; r_q_oidx <= '0; r_q_omax <= r_q_age[0];
                r_p_cnt <= '0;
                r_m_cnt <= '0;
                r_w <= '0;
            end
            if (i_cmd.scan) begin
                if (r_i < SW'(CE)) begin
                    if (r_c_vld[ci] && r_c_ip[ci] == r_ip && !r_c_hit) begin
                        r_c_hit <= 1'b1; r_c_hidx <= ci;
                    end
                    if (!r_c_vld[ci] && !r_c_free) begin
                        r_c_free <= 1'b1; r_c_fidx <= ci;
                    end
                    if (r_c_age[ci] > r_c_omax) begin
                        r_c_omax <= r_c_age[ci]; r_c_oidx <= ci;
                    end
                end
                if (r_i < SW'(RE)) begin
                    if (r_q_vld[qi] && r_q_ip[qi] == r_ip && !r_q_hit) begin
                        r_q_hit <= 1'b1; r_q_hidx <= qi;
                    end
                    if (!r_q_vld[qi] && !r_q_free) begin
                        r_q_free <= 1'b1; r_q_fidx <= qi;
                    end
                    if (r_q_age[qi] > r_q_omax) begin
                        r_q_omax <= r_q_age[qi]; r_q_oidx <= qi;
                    end
                end
                if (r_i < SW'(PE) && r_p_vld[fi]) r_p_cnt <= r_p_cnt + 1'b1;
                if (r_i < SW'(PE) && r_p_vld[fi] && r_p_ip[fi] == r_ip)
                    r_m_cnt <= r_m_cnt + 1'b1;
                r_i <= r_i + SW'(1);
            end
            if (i_cmd.decide) begin
                r_i <= '0;
                r_fdone <= !arp_learn;
                r_reply_due <= arp_learn && r_rep;
                if (r_op == arc_pkg::OP_SEND) begin
                    if (r_c_hit) begin
                        r_res <= 1'b1; r_res_kind <= arc_pkg::KIND_IPV4;
                        r_res_dmac <= r_c_mac[r_c_hidx]; r_res_tip <= '0;
                        r_res_tmac <= '0; r_res_tag <= r_tag; r_res_last <= 1'b1;
                    end else begin
                        if (!r_q_hit || r_q_age[r_q_hidx] >= i_retry_ms) begin
                            logic [arc_pkg::RIdxW-1:0] q;
                            q = r_q_hit ? r_q_hidx : (r_q_free ? r_q_fidx : r_q_oidx);
                            r_q_ip[q] <= r_ip; r_q_age[q] <= '0; r_q_vld[q] <= 1'b1;
                            r_res <= 1'b1; r_res_kind <= arc_pkg::KIND_ARP_REQ;
                            r_res_dmac <= 48'hFFFF_FFFF_FFFF; r_res_tip <= r_ip;
                            r_res_tmac <= '0; r_res_tag <= '0; r_res_last <= 1'b1;
                        end
                        if (r_p_cnt == arc_pkg::PCntW'(PE)) begin
                            for (int k = 1; k < PE; k++) begin
                                r_p_ip[k-1] <= r_p_ip[k]; r_p_tag[k-1] <= r_p_tag[k];
                            end
                            r_p_ip[PE-1] <= r_ip; r_p_tag[PE-1] <= r_tag;
                        end else begin
                            r_p_ip[r_p_cnt[arc_pkg::PIdxW-1:0]] <= r_ip;
                            r_p_tag[r_p_cnt[arc_pkg::PIdxW-1:0]] <= r_tag;
                            r_p_vld[r_p_cnt[arc_pkg::PIdxW-1:0]] <= 1'b1;
                        end
                    end
                end else if (r_accept_frame) begin
                    if (r_is_ipv4) begin
                        r_res <= 1'b1; r_res_kind <= arc_pkg::KIND_DELIVER;
                        r_res_dmac <= '0; r_res_tip <= '0; r_res_tmac <= '0;
                        r_res_tag <= '0; r_res_last <= 1'b1;
                    end else begin
                        logic [arc_pkg::CIdxW-1:0] c;
                        c = r_c_hit ? r_c_hidx : (r_c_free ? r_c_fidx : r_c_oidx);
                        r_c_ip[c] <= r_ip; r_c_mac[c] <= r_mac;
                        r_c_age[c] <= '0; r_c_vld[c] <= 1'b1;
                        if (r_q_hit) begin
                            r_q_vld[r_q_hidx] <= 1'b0; r_q_age[r_q_hidx] <= '0;
                        end
                    end
                end
            end
            // flush: one pending entry per step, emits stall it
            if (i_cmd.flush) begin
                if (fvalid) begin
                    if (r_p_ip[fi] == r_ip) begin
                        r_res <= 1'b1; r_res_kind <= arc_pkg::KIND_IPV4;
                        r_res_dmac <= r_mac; r_res_tip <= '0; r_res_tmac <= '0;
                        r_res_tag <= r_p_tag[fi];
                        r_res_last <= (r_m_cnt == arc_pkg::PCntW'(1)) && !r_reply_due;
                        r_m_cnt <= r_m_cnt - 1'b1;
                    end else begin
                        r_p_ip[r_w[arc_pkg::PIdxW-1:0]]  <= r_p_ip[fi];
                        r_p_tag[r_w[arc_pkg::PIdxW-1:0]] <= r_p_tag[fi];
                        r_w <= r_w + 1'b1;
                    end
                    r_i <= fnext;
                end else begin
                    // clear tail valid bits, then reply
                    for (int k = 0; k < PE; k++)
                        if (arc_pkg::PCntW'(k) >= r_w) r_p_vld[k] <= 1'b0;
                    r_i <= SW'(PE);
                    r_fdone <= 1'b1;
                    if (r_reply_due) begin
                        r_res <= 1'b1; r_res_kind <= arc_pkg::KIND_ARP_REP;
                        r_res_dmac <= r_mac; r_res_tip <= r_ip; r_res_tmac <= r_mac;
                        r_res_tag <= '0; r_res_last <= 1'b1; r_reply_due <= 1'b0;
                    end
                end
            end
            if (i_cmd.tick) begin
                if (r_i < SW'(CE) && r_c_vld[ci]) begin
                    if ((c_sum > 21'hFFFFF ? 20'hFFFFF : c_sum[19:0]) >= i_life_ms) begin
                        r_c_vld[ci] <= 1'b0; r_c_age[ci] <= '0;
                    end else begin
                        r_c_age[ci] <= c_sum[19:0];
                    end
                end
                if (r_i < SW'(RE) && r_q_vld[qi])
                    r_q_age[qi] <= q_sum[16] ? 16'hFFFF : q_sum[15:0];
                r_i <= r_i + SW'(1);
            end
            if (i_cmd.emit) begin
                o_valid <= 1'b1;
                o_kind <= r_res_kind; o_dst_mac <= r_res_dmac; o_target_ip <= r_res_tip;
                o_target_mac <= r_res_tmac; o_out_tag <= r_res_tag; o_last <= r_res_last;
                r_res <= 1'b0;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.scan_done  = scan_done;
        o_sts.flush_done = r_fdone && !r_res;
        o_sts.tick_done  = scan_done;
        o_sts.has_result = r_res;
        o_sts.out_busy   = o_valid && !i_ready;
    end

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> o_valid) else $error("emit lost");
    a_res_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_res) else $error("emit without result");
    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !(o_valid && !i_ready)) else $error("output overwritten");
endmodule
`default_nettype wire

/* design/arc_ctrl.sv */
// arc_ctrl: sequencer for scan, update, flush and aging passes
// depends on arc_pkg
`default_nettype none
module arc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_op,
    input  wire arc_pkg::t_sts i_sts,
    output arc_pkg::t_cmd      o_cmd
);
    arc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= arc_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    assign o_ready = (r_state == arc_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            arc_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.clr_scan = 1'b1;
                    priority if (i_op == arc_pkg::OP_TICK) n_state = arc_pkg::S_TICK;
                    else if (i_op == arc_pkg::OP_SEND || i_op == arc_pkg::OP_RECV)
                        n_state = arc_pkg::S_SCAN;
                    else n_state = arc_pkg::S_IDLE;
                end
            end
            arc_pkg::S_SCAN: begin
                if (i_sts.scan_done) n_state = arc_pkg::S_DECIDE;
                else o_cmd.scan = 1'b1;
            end
            arc_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = (i_sts.op == arc_pkg::OP_SEND) ? arc_pkg::S_EMIT : arc_pkg::S_FLUSH;
            end
            arc_pkg::S_FLUSH: begin
                priority if (i_sts.has_result) n_state = arc_pkg::S_EMIT;
                else if (i_sts.flush_done) n_state = arc_pkg::S_WAIT;
                else o_cmd.flush = 1'b1;
            end
            arc_pkg::S_EMIT: begin
                priority if (!i_sts.has_result) n_state = arc_pkg::S_WAIT;
                else if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = (i_sts.op == arc_pkg::OP_RECV) ? arc_pkg::S_FLUSH
                                                              : arc_pkg::S_WAIT;
                end
            end
            arc_pkg::S_TICK: begin
                if (i_sts.tick_done) n_state = arc_pkg::S_WAIT;
                else o_cmd.tick = 1'b1;
            end
            arc_pkg::S_WAIT: begin
                n_state = arc_pkg::S_IDLE;
            end
            default: n_state = arc_pkg::S_IDLE;
        endcase
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> o_ready) else $error("load outside idle");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.scan, o_cmd.decide, o_cmd.flush, o_cmd.tick, o_cmd.emit}))
        else $error("overlapping commands");
endmodule
`default_nettype wire

/* bench/arp_resolver_cache_unit_tb.sv */
// arp_resolver_cache_unit_tb: self-checking bench for the arp resolution cache
// depends on arc_pkg and arp_resolver_cache_unit; holds its own table model
// and compares every result transfer against it
`timescale 1ns / 100ps
`default_nettype none
module arp_resolver_cache_unit_tb;

    localparam int LIMIT = 600000;
    localparam logic [47:0] BCAST = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] tag;
        logic [31:0] hop_ip;
        logic [47:0] dst_mac;
        logic        is_ipv4;
        logic        ok;
        logic        is_req;
        logic [31:0] snd_ip;
        logic [47:0] snd_mac;
        logic [31:0] tgt_ip;
        logic [15:0] el_ms;
    } t_event;

    typedef struct {
        logic [1:0]  kind;
        logic [47:0] dst_mac;
        logic [31:0] tgt_ip;
        logic [47:0] tgt_mac;
        logic [15:0] tag;
        logic        last;
    } t_frame;

    // dut ports, every input known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = '0;
    logic [15:0] i_dgram_tag = '0;
    logic [31:0] i_next_hop_ip = '0;
    logic [47:0] i_frame_dst_mac = '0;
    logic        i_frame_is_ipv4 = 1'b0, i_parse_ok = 1'b0, i_arp_is_request = 1'b0;
    logic [31:0] i_arp_sender_ip = '0, i_arp_target_ip = '0;
    logic [47:0] i_arp_sender_mac = '0;
    logic [15:0] i_elapsed_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [47:0] o_dst_mac, o_target_mac;
    logic [31:0] o_target_ip;
    logic [15:0] o_out_tag;
    logic        o_last;

    arp_resolver_cache_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // table model: own copy of configuration and all three tables
    // ---------------------------------------------------------------
    logic [47:0] m_own_mac;
    logic [31:0] m_own_ip;
    logic [15:0] m_retry;
    logic [19:0] m_life;
    logic [31:0] arp_ip [arc_pkg::CacheEntries];
    logic [47:0] arp_mac [arc_pkg::CacheEntries];
    logic [19:0] arp_age [arc_pkg::CacheEntries];
    bit          arp_vld [arc_pkg::CacheEntries];
    logic [31:0] park_ip [arc_pkg::PendEntries];
    logic [15:0] park_tag [arc_pkg::PendEntries];
    bit          park_vld [arc_pkg::PendEntries];
    logic [31:0] asked_ip [arc_pkg::ReqEntries];
    logic [15:0] asked_age [arc_pkg::ReqEntries];
    bit          asked_vld [arc_pkg::ReqEntries];

    t_frame expected_frames[$];
    t_event pending_events[$];
    int     fails = 0;

    function automatic void add_frame(logic [1:0] k, logic [47:0] d, logic [31:0] ip,
                                      logic [47:0] m, logic [15:0] t);
        t_frame f;
        f.kind = k; f.dst_mac = d; f.tgt_ip = ip; f.tgt_mac = m; f.tag = t; f.last = 1'b0;
        expected_frames = {expected_frames, f};
    endfunction

    function automatic void queue_event(t_event e);
        pending_events = {pending_events, e};
    endfunction

    function automatic int find_mapping(logic [31:0] ip);
        for (int i = 0; i < arc_pkg::CacheEntries; i++)
            if (arp_vld[i] && arp_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic int find_asked(logic [31:0] ip);
        for (int i = 0; i < arc_pkg::ReqEntries; i++)
            if (asked_vld[i] && asked_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic void resolve_event(t_event e);
        int n0, s, r, cnt, w, sum;
        n0 = expected_frames.size();
        case (e.op)
            arc_pkg::OP_SEND: begin
                s = find_mapping(e.hop_ip);
                if (s >= 0) begin
                    add_frame(arc_pkg::KIND_IPV4, arp_mac[s], '0, '0, e.tag);
                end else begin
                    r = find_asked(e.hop_ip);
                    if (r < 0 || asked_age[r] >= m_retry) begin
                        if (r < 0)
                            for (int i = 0; i < arc_pkg::ReqEntries && r < 0; i++)
                                if (!asked_vld[i]) r = i;
                        if (r < 0) begin
                            r = 0;
                            for (int i = 1; i < arc_pkg::ReqEntries; i++)
                                if (asked_age[i] > asked_age[r]) r = i;
                        end
                        asked_ip[r] = e.hop_ip; asked_age[r] = '0; asked_vld[r] = 1'b1;
                        add_frame(arc_pkg::KIND_ARP_REQ, BCAST, e.hop_ip, '0, '0);
                    end
                    // park the datagram, dropping the oldest when full
                    cnt = 0;
                    while (cnt < arc_pkg::PendEntries && park_vld[cnt]) cnt++;
                    if (cnt == arc_pkg::PendEntries) begin
                        for (int i = 1; i < arc_pkg::PendEntries; i++) begin
                            park_ip[i-1] = park_ip[i]; park_tag[i-1] = park_tag[i];
                        end
                        cnt = arc_pkg::PendEntries - 1;
                    end
                    park_ip[cnt] = e.hop_ip; park_tag[cnt] = e.tag; park_vld[cnt] = 1'b1;
                end
            end
            arc_pkg::OP_RECV: begin
                if ((e.dst_mac == BCAST || e.dst_mac == m_own_mac) && e.ok) begin
                    if (e.is_ipv4) begin
                        add_frame(arc_pkg::KIND_DELIVER, '0, '0, '0, '0);
                    end else begin
                        // learn: known ip in place, else free slot, else oldest
                        s = find_mapping(e.snd_ip);
                        if (s < 0)
                            for (int i = 0; i < arc_pkg::CacheEntries && s < 0; i++)
                                if (!arp_vld[i]) s = i;
                        if (s < 0) begin
                            s = 0;
                            for (int i = 1; i < arc_pkg::CacheEntries; i++)
                                if (arp_age[i] > arp_age[s]) s = i;
                        end
                        arp_ip[s] = e.snd_ip; arp_mac[s] = e.snd_mac;
                        arp_age[s] = '0; arp_vld[s] = 1'b1;
                        r = find_asked(e.snd_ip);
                        if (r >= 0) begin
                            asked_vld[r] = 1'b0; asked_age[r] = '0;
                        end
                        w = 0;
                        for (int i = 0; i < arc_pkg::PendEntries && park_vld[i]; i++) begin
                            if (park_ip[i] == e.snd_ip) begin
                                add_frame(arc_pkg::KIND_IPV4, e.snd_mac, '0, '0, park_tag[i]);
                            end else begin
                                park_ip[w] = park_ip[i]; park_tag[w] = park_tag[i]; w++;
                            end
                        end
                        for (int i = w; i < arc_pkg::PendEntries; i++) park_vld[i] = 1'b0;
                        if (e.is_req && e.tgt_ip == m_own_ip)
                            add_frame(arc_pkg::KIND_ARP_REP, e.snd_mac, e.snd_ip,
                                      e.snd_mac, '0);
                    end
                end
            end
            arc_pkg::OP_TICK: begin
                for (int i = 0; i < arc_pkg::CacheEntries; i++) begin
                    if (arp_vld[i]) begin
                        sum = int'(arp_age[i]) + int'(e.el_ms);
                        arp_age[i] = (sum > 'hFFFFF) ? 20'hFFFFF : 20'(sum);
                        if (arp_age[i] >= m_life) begin
                            arp_vld[i] = 1'b0; arp_age[i] = '0;
                        end
                    end
                end
                for (int i = 0; i < arc_pkg::ReqEntries; i++)
                    if (asked_vld[i]) begin
                        sum = int'(asked_age[i]) + int'(e.el_ms);
                        asked_age[i] = (sum > 'hFFFF) ? 16'hFFFF : 16'(sum);
                    end
            end
            default: ;
        endcase
        if (expected_frames.size() > n0)
            expected_frames[expected_frames.size()-1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // driver: offers queued events, predicts at each accepted transfer
    // ---------------------------------------------------------------
    t_event cur_event;
    int     send_gap = 0;
    bit     quiet = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                resolve_event(cur_event);
            if (i_valid && !o_ready) begin
                // hold the offered event until it is taken
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                cur_event = pending_events.pop_front();
                i_op <= cur_event.op;
                i_dgram_tag <= cur_event.tag;
                i_next_hop_ip <= cur_event.hop_ip;
                i_frame_dst_mac <= cur_event.dst_mac;
                i_frame_is_ipv4 <= cur_event.is_ipv4;
                i_parse_ok <= cur_event.ok;
                i_arp_is_request <= cur_event.is_req;
                i_arp_sender_ip <= cur_event.snd_ip;
                i_arp_sender_mac <= cur_event.snd_mac;
                i_arp_target_ip <= cur_event.tgt_ip;
                i_elapsed_ms <= cur_event.el_ms;
                i_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 19);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: random stalls, one long hold-off on request
    // ---------------------------------------------------------------
    int  stall_left = 0;
    bit  holdoff_req = 1'b0;
    bit  holdoff_done = 1'b0;
    t_frame want;

    always @(posedge i_clk) begin
        if (holdoff_req && !holdoff_done) begin
            holdoff_done = 1'b1;
            stall_left = 400;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_frames.size() == 0) begin
                $error("result transfer with nothing expected: kind %0d", o_kind);
                fails++;
            end else begin
                want = expected_frames.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind); fails++;
                end
                if (o_dst_mac !== want.dst_mac) begin
                    $error("dst_mac: expected %h, got %h", want.dst_mac, o_dst_mac); fails++;
                end
                if (o_target_ip !== want.tgt_ip) begin
                    $error("target_ip: expected %h, got %h", want.tgt_ip, o_target_ip);
                    fails++;
                end
                if (o_target_mac !== want.tgt_mac) begin
                    $error("target_mac: expected %h, got %h", want.tgt_mac, o_target_mac);
                    fails++;
                end
                if (o_out_tag !== want.tag) begin
                    $error("out_tag: expected %h, got %h", want.tag, o_out_tag); fails++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last); fails++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // watchdog
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_event blank_event(logic [1:0] op);
        t_event e;
        e.op = op; e.tag = '0; e.hop_ip = '0; e.dst_mac = BCAST; e.is_ipv4 = 1'b0;
        e.ok = 1'b1; e.is_req = 1'b0; e.snd_ip = '0; e.snd_mac = '0; e.tgt_ip = '0;
        e.el_ms = '0;
        return e;
    endfunction

    task automatic send_dgram(logic [15:0] tag, logic [31:0] ip);
        t_event e = blank_event(arc_pkg::OP_SEND);
        e.tag = tag; e.hop_ip = ip;
        queue_event(e);
    endtask

    task automatic recv_arp(logic [47:0] dst, logic req, logic [31:0] sip,
                            logic [47:0] smac, logic [31:0] tip);
        t_event e = blank_event(arc_pkg::OP_RECV);
        e.dst_mac = dst; e.is_req = req; e.snd_ip = sip; e.snd_mac = smac; e.tgt_ip = tip;
        queue_event(e);
    endtask

    task automatic tick(logic [15:0] ms);
        t_event e = blank_event(arc_pkg::OP_TICK);
        e.el_ms = ms;
        queue_event(e);
    endtask

    // small ip pool so sends hit, park and get flushed often
    function automatic logic [31:0] pool_ip();
        return ($urandom_range(0, 9) == 0) ? 32'($urandom())
                                           : 32'hC0A8_0100 + 32'($urandom_range(0, 23));
    endfunction

    task automatic random_events(int count);
        t_event e;
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            e = blank_event(arc_pkg::OP_RECV);
            e.tag = 16'($urandom()); e.hop_ip = pool_ip(); e.snd_ip = pool_ip();
            e.snd_mac = 48'({$urandom(), $urandom()}); e.is_req = 1'($urandom_range(0, 1));
            e.tgt_ip = ($urandom_range(0, 1) != 0) ? m_own_ip : 32'($urandom());
            e.dst_mac = ($urandom_range(0, 1) != 0) ? BCAST : m_own_mac;
            e.el_ms = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                  : 16'($urandom_range(0, 3000));
            if (pick < 40) begin
                e.op = arc_pkg::OP_SEND;
            end else if (pick < 68) begin
                e.is_ipv4 = 1'b0;
            end else if (pick < 78) begin
                e.is_ipv4 = 1'b1;
            end else if (pick < 93) begin
                e.op = arc_pkg::OP_TICK;
            end else begin
                // noise: unknown op, foreign frame or bad parse, all fields random
                e.op = 2'($urandom_range(0, 3)); e.is_ipv4 = 1'($urandom_range(0, 1));
                e.dst_mac = 48'({$urandom(), $urandom()});
                e.ok = 1'($urandom_range(0, 1));
                if (pick < 95) e.op = 2'd3;
            end
            queue_event(e);
        end
    endtask

    task automatic wait_quiet();
        while (pending_events.size() > 0 || i_valid || expected_frames.size() > 0)
            @(posedge i_clk);
        // a dropped or silent event may still be in flight
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        wait_quiet();
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 3'b000}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            arc_pkg::REG_OWN_MAC: m_own_mac = value[47:0];
            arc_pkg::REG_OWN_IP:  m_own_ip = value[31:0];
            arc_pkg::REG_RETRY:   m_retry = value[15:0];
            default:              m_life = value[19:0];
        endcase
    endtask

    // ---------------------------------------------------------------
    // sequence of phases
    // ---------------------------------------------------------------
    initial begin
        m_own_mac = '0; m_own_ip = '0; m_retry = 16'd5000; m_life = 20'd30000;
        for (int i = 0; i < arc_pkg::CacheEntries; i++) begin
            arp_vld[i] = 1'b0; arp_age[i] = '0; arp_ip[i] = '0; arp_mac[i] = '0;
        end
        for (int i = 0; i < arc_pkg::PendEntries; i++) park_vld[i] = 1'b0;
        for (int i = 0; i < arc_pkg::ReqEntries; i++) begin
            asked_vld[i] = 1'b0; asked_age[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset settings: own mac zero so a zero dst is ours
        send_dgram(16'h0000, 32'h0A00_0001);            // miss, request out
        send_dgram(16'hFFFF, 32'h0A00_0001);            // suppressed, parked
        tick(16'd4999);
        send_dgram(16'h1234, 32'h0A00_0001);            // still suppressed
        tick(16'd1);
        send_dgram(16'h5678, 32'h0A00_0001);            // retry time reached
        recv_arp(BCAST, 1'b0, 32'h0A00_0001, 48'h0200_0000_0001, '0); // flush all
        send_dgram(16'hABCD, 32'h0A00_0001);            // hit
        recv_arp(48'h0, 1'b1, 32'hFFFF_FFFF, BCAST, 32'h0); // request for us
        begin
            t_event e = blank_event(arc_pkg::OP_RECV);
            e.is_ipv4 = 1'b1; queue_event(e);                    // delivered
            e.dst_mac = 48'h0000_0000_0002; queue_event(e);      // foreign
            e.dst_mac = BCAST; e.ok = 1'b0; queue_event(e);      // bad parse
            e = blank_event(2'd3); queue_event(e);               // unknown op
        end
        // overfill parking and the request table, then cache by learning
        for (int i = 0; i < 18; i++) send_dgram(16'(16'h0100 + i), 32'h0B00_0000 + i);
        recv_arp(BCAST, 1'b0, 32'h0B00_0011, 48'h0200_0000_0011, '0);
        tick(16'hFFFF);                                  // evicts, ages saturate
        tick(16'hFFFF);
        for (int i = 0; i < 18; i++)
            recv_arp(BCAST, 1'b0, 32'h0C00_0000 + i, 48'h0400_0000_0000 + i, '0);
        random_events(15);

        write_reg(arc_pkg::REG_OWN_MAC, {16'h0, 16'($urandom()), $urandom()});
        write_reg(arc_pkg::REG_OWN_IP, {32'h0, 32'hC0A8_0100 + 32'($urandom_range(0, 23))});
        write_reg(arc_pkg::REG_RETRY, 64'd1);
        write_reg(arc_pkg::REG_LIFE, 64'd1048575);
        random_events(20);
        holdoff_req <= 1'b1;                             // long output stall
        random_events(20);

        write_reg(arc_pkg::REG_OWN_MAC, 64'h0000_FFFF_FFFF_FFFE);
        write_reg(arc_pkg::REG_OWN_IP, 64'h0000_0000_FFFF_FFFF);
        write_reg(arc_pkg::REG_RETRY, 64'd65535);
        write_reg(arc_pkg::REG_LIFE, 64'd1);
        random_events(25);

        write_reg(arc_pkg::REG_OWN_IP, 64'h0000_0000_C0A8_0105);
        write_reg(arc_pkg::REG_RETRY, 64'd3000);
        write_reg(arc_pkg::REG_LIFE, 64'd20000);
        quiet = 1'b1;
        random_events(30);

        wait_quiet();
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
design/arc_pkg.sv
design/arc_dp.sv
design/arc_ctrl.sv
design/arp_resolver_cache_unit.sv
bench/arp_resolver_cache_unit_tb.sv
